@@ rtl/scs_pkg.sv @@
// ---------------------------------------------------------------------------
// Split count sketch package
// Shared command codes, sequencer states and fixed field widths.
// ---------------------------------------------------------------------------
package scs_pkg;

   localparam int unsigned WordIdxBits = 10;
   localparam int unsigned CntIdxBits  = 3;
   localparam int unsigned HighBits    = 28;
   localparam int unsigned EstBits     = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_SORT,
      ST_MEAN,
      ST_OUT
   } state_type;

endpackage

@@ rtl/split_count_sketch_core.sv @@
// ---------------------------------------------------------------------------
// Split count sketch core
// Count sketch over one counter memory; each counter is a low part and a
// signed high part forming one wrapping two's complement value.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel: one request per key with its command and hash outputs.
//   rsp_ channel: one estimate for every query request; insert and delete
//   requests (and the unused command code) give no response.
//   Each request walks its rows through one read-modify-write port of the
//   counter memory: each row is read, then updated or captured; queries add
//   a short sort of the captured values (HASH_COUNTERS passes), a mean step
//   and an output handoff. Rows whose address repeats within a request are
//   skipped. The memory port is the limit: rows are serial and one request
//   is in flight at a time.
//   After reset a clearing pass writes zero to all WORDS*COUNTERS_PER_WORD
//   counters, one per cycle, before req_tready rises.
//   A stalled receiver holds the estimate in rsp_tdata; no new request is
//   taken until it is delivered.
// ---------------------------------------------------------------------------
module split_count_sketch_core
   import scs_pkg::*;
#(
   parameter int unsigned WORDS             = 1024,
   parameter int unsigned COUNTERS_PER_WORD = 8,
   parameter int unsigned HASH_WORDS        = 2,
   parameter int unsigned HASH_COUNTERS     = 4,
   parameter int unsigned LOW_BITS          = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] command, [11:2] word_index_0, [21:12] word_index_1,
   // [24:22] counter_index_0, [27:25] counter_index_1,
   // [30:28] counter_index_2, [33:31] counter_index_3, [37:34] sign_bits
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] estimate
   output logic [31:0] rsp_tdata
);

   localparam int unsigned Depth    = WORDS * COUNTERS_PER_WORD;
   localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned RowBits  = (HASH_COUNTERS > 1) ? $clog2(HASH_COUNTERS) : 1;
   localparam int unsigned CntBits  = $clog2(HASH_COUNTERS + 1);
   localparam int unsigned TotBits  = LOW_BITS + HighBits;
   localparam int unsigned ValBits  = TotBits + 1;

   // counter memory, low and high parts side by side
   logic [LOW_BITS-1:0] low_mem  [Depth];
   logic [HighBits-1:0] high_mem [Depth];
   logic [LOW_BITS-1:0] low_rd_ff;
   logic [HighBits-1:0] high_rd_ff;

   state_type state_ff, state_in;
   logic [AddrBits-1:0] clr_ff, clr_in;
   logic [39:0] req_ff, req_in;
   logic [RowBits-1:0] row_ff, row_in;
   logic phase_ff, phase_in;
   logic [AddrBits-1:0] addr_ff [HASH_COUNTERS];
   logic signed [ValBits-1:0] val_ff [HASH_COUNTERS];
   logic [CntBits-1:0] used_ff, used_in;
   logic [RowBits-1:0] pass_ff, pass_in;
   logic [EstBits-1:0] est_ff, est_in;

   logic we;
   logic [AddrBits-1:0] waddr, raddr;
   logic [TotBits-1:0] wdata;
   logic cap, sort_en;

   // row address decode
   logic [1:0] cmd;
   logic [WordIdxBits-1:0] wfield;
   logic [CntIdxBits-1:0] cfield;
   logic minus, dup;
   logic [AddrBits-1:0] row_addr;
   logic [AddrBits+6:0] addr_wide;

   always_comb begin
      logic [1:0] cf;
      cmd = req_ff[1:0];
      cf  = 2'(row_ff % 4);
      if (1'((row_ff % HASH_WORDS) & 1) == 1'b1)
         wfield = req_ff[21:12];
      else
         wfield = req_ff[11:2];
      case (cf)
         2'd0:    cfield = req_ff[24:22];
         2'd1:    cfield = req_ff[27:25];
         2'd2:    cfield = req_ff[30:28];
         default: cfield = req_ff[33:31];
      endcase
      minus = req_ff[34 + cf];
      addr_wide = (AddrBits+7)'(((AddrBits+7)'(wfield) % WORDS) * COUNTERS_PER_WORD
                + cfield % COUNTERS_PER_WORD);
      row_addr = addr_wide[AddrBits-1:0];
      dup = 1'b0;
      for (int i = 0; i < HASH_COUNTERS; i++) begin
         if (CntBits'(i) < used_ff && addr_ff[i] == row_addr)
            dup = 1'b1;
      end
   end

   // combined value update
   logic [TotBits-1:0] raw;
   logic signed [ValBits-1:0] sval;
   logic add;
   always_comb begin
      raw  = {high_rd_ff, low_rd_ff};
      sval = ValBits'(signed'(raw));
      add  = (cmd == CMD_INSERT) != minus;
      if (add) wdata = raw + TotBits'(1);
      else     wdata = raw - TotBits'(1);
   end

   // median of sorted values
   logic signed [ValBits:0] msum;
   always_comb begin
      logic [CntBits-1:0] h;
      h = used_ff >> 1;
      if (used_ff[0])
         msum = {val_ff[RowBits'(h)], 1'b0};
      else
         msum = (ValBits+1)'(val_ff[RowBits'(h)]) + (ValBits+1)'(val_ff[RowBits'(h - 1'b1)]);
   end

   // sequencer
   always_comb begin
      logic signed [ValBits:0] q;
      state_in = state_ff;
      clr_in   = clr_ff;
      req_in   = req_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      used_in  = used_ff;
      pass_in  = pass_ff;
      est_in   = est_ff;
      we       = 1'b0;
      waddr    = row_addr;
      cap      = 1'b0;
      sort_en  = 1'b0;
      raddr    = row_addr;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      q = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrBits'(Depth - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               req_in = req_tdata;
               row_in = '0;
               phase_in = 1'b0;
               used_in = '0;
               if (req_tdata[1:0] != CMD_NONE) state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (!dup) begin
                  cap = 1'b1;
                  used_in = used_ff + 1'b1;
                  if (cmd != CMD_QUERY) we = 1'b1;
               end
               row_in = row_ff + 1'b1;
               if (row_ff == RowBits'(HASH_COUNTERS - 1)) begin
                  pass_in = '0;
                  state_in = (cmd == CMD_QUERY) ? ST_SORT : ST_IDLE;
               end
            end
         end
         ST_SORT: begin
            sort_en = 1'b1;
            pass_in = pass_ff + 1'b1;
            if (pass_ff == RowBits'(HASH_COUNTERS - 1)) state_in = ST_MEAN;
         end
         ST_MEAN: begin
            // halve toward zero
            q = msum;
            if (q[ValBits]) q = q + 1'b1;
            q = q >>> 1;
            est_in = q[EstBits-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         used_ff  <= used_in;
      end
      req_ff   <= req_in;
      row_ff   <= row_in;
      phase_ff <= phase_in;
      pass_ff  <= pass_in;
      est_ff   <= est_in;
   end

   // capture row address and signed value; odd-even transposition sort
   always_ff @(posedge clock) begin
      if (cap) begin
         addr_ff[RowBits'(used_ff)] <= row_addr;
         val_ff[RowBits'(used_ff)]  <= minus ? -sval : sval;
      end else if (sort_en) begin
         for (int i = 0; i + 1 < HASH_COUNTERS; i++) begin
            if ((i % 2) == (pass_ff % 2) && CntBits'(i + 1) < used_ff
                && val_ff[i] > val_ff[i+1]) begin
               val_ff[i]   <= val_ff[i+1];
               val_ff[i+1] <= val_ff[i];
            end
         end
      end
   end

   // counter memory port
   always_ff @(posedge clock) begin
      if (we) begin
         low_mem[waddr]  <= (state_ff == ST_CLEAR) ? '0 : wdata[LOW_BITS-1:0];
         high_mem[waddr] <= (state_ff == ST_CLEAR) ? '0 : wdata[TotBits-1:LOW_BITS];
      end
      low_rd_ff  <= low_mem[raddr];
      high_rd_ff <= high_mem[raddr];
   end

   assign rsp_tdata = est_ff;

`ifndef SYNTH
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_tvalid && !req_tready)
      else $error("busy during clear");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CntBits'(HASH_COUNTERS))
      else $error("row count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   a_query_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MEAN |-> used_ff != '0)
      else $error("empty query");
`endif

endmodule
